// ----- src/cpp_pkg.sv -----
// Shared constants, types and helpers for the camera perspective projector.
package cpp_pkg;

  localparam int COORD_W   = 32;
  localparam int TRIG_W    = 16;
  localparam int FOCAL_W   = 31;
  localparam int FRAC_BITS = 16;
  localparam int TRIG_FRAC = 14;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_COSINE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_SINE     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_COSINE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_SINE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_SCALE  = 4'd7;

  localparam logic signed [TRIG_W-1:0] RESET_COSINE = 16'sd16384;
  localparam logic [FOCAL_W-1:0]       RESET_FOCAL  = 31'd32768000;

  // projection product, |product| + divisor/2, quotient bits kept
  localparam int PROD_W     = COORD_W + FOCAL_W + 1;
  localparam int NUM_W      = 2 * COORD_W - 1;
  localparam int QUO_BITS   = COORD_W + 1;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEP;

  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 768;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [COORD_W-1:0]  rem;
    logic [QUO_BITS-1:0] bits;  // numerator bits on top, quotient bits enter at bottom
    logic                ovf;
    logic                pos;   // product was >= 0
  } div_lane_t;

  typedef struct packed {
    logic               front;
    logic [COORD_W-1:0] den;
    div_lane_t          lx;
    div_lane_t          ly;
  } div_word_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/cpp_rotate.sv -----
// Two-stage plane rotation by a Q1.14 cosine/sine pair with rounding.
module cpp_rotate
  import cpp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  coord_t                   a,
  input  coord_t                   b,
  input  logic signed [TRIG_W-1:0] cosv,
  input  logic signed [TRIG_W-1:0] sinv,
  input  coord_t                   carry_in,
  output logic                     out_valid,
  output coord_t                   p,
  output coord_t                   q,
  output coord_t                   carry_out
);

  localparam int MUL_W = COORD_W + TRIG_W;
  localparam int SUM_W = MUL_W + 2;

  logic signed [MUL_W-1:0] m_ac, m_bs, m_bc, m_as;
  coord_t                  carry_m;
  logic                    valid_m;
  logic signed [SUM_W-1:0] sum_p, sum_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_m   <= in_valid;
      out_valid <= valid_m;
    end
    if (en) begin
      m_ac      <= a * cosv;
      m_bs      <= b * sinv;
      m_bc      <= b * cosv;
      m_as      <= a * sinv;
      carry_m   <= carry_in;
      p         <= sat32(64'(sum_p >>> TRIG_FRAC));
      q         <= sat32(64'(sum_q >>> TRIG_FRAC));
      carry_out <= carry_m;
    end
  end

  // round half up
  assign sum_p = SUM_W'(m_ac) + SUM_W'(m_bs) + SUM_W'(1 <<< (TRIG_FRAC - 1));
  assign sum_q = SUM_W'(m_bc) - SUM_W'(m_as) + SUM_W'(1 <<< (TRIG_FRAC - 1));

endmodule

// ----- src/cpp_project.sv -----
// Focal products and divider operand setup.
module cpp_project
  import cpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  coord_t             x1,
  input  coord_t             y2,
  input  coord_t             z2,
  input  logic [FOCAL_W-1:0] focal,
  output logic               out_valid,
  output div_word_t          out_word
);

  localparam int TOP_W = NUM_W - QUO_BITS;

  logic signed [PROD_W-1:0] num_x, num_y;
  coord_t                   z_m;
  logic                     valid_m;
  logic [COORD_W-1:0]       den;
  div_word_t                word_next;

  function automatic div_lane_t lane_init(input logic signed [PROD_W-1:0] num,
                                          input logic [COORD_W-1:0] d);
    logic [PROD_W-1:0] an;
    logic [NUM_W-1:0]  n;
    div_lane_t         l;
    an = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    n  = an[NUM_W-1:0] + NUM_W'(d >> 1);
    l.ovf  = {{(COORD_W-TOP_W){1'b0}}, n[NUM_W-1:QUO_BITS]} >= d;
    l.rem  = l.ovf ? '0 : COORD_W'(n[NUM_W-1:QUO_BITS]);
    l.bits = n[QUO_BITS-1:0];
    l.pos  = !num[PROD_W-1];
    return l;
  endfunction

  assign den = COORD_W'(0) - COORD_W'(z_m);

  always_comb begin
    word_next.front = z_m[COORD_W-1];
    word_next.den   = den;
    word_next.lx    = lane_init(num_x, den);
    word_next.ly    = lane_init(num_y, den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_m   <= in_valid;
      out_valid <= valid_m;
    end
    if (en) begin
      num_x    <= x1 * $signed({1'b0, focal});
      num_y    <= y2 * $signed({1'b0, focal});
      z_m      <= z2;
      out_word <= word_next;
    end
  end

endmodule

// ----- src/cpp_divider.sv -----
// Pipelined restoring divider, two lanes sharing one divisor.
module cpp_divider
  import cpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  div_word_t             stg     [DIV_STAGES];
  div_word_t             stg_next[DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [COORD_W-1:0] d);
    logic [COORD_W:0] trial;
    div_lane_t        r;
    trial = {l.rem, l.bits[QUO_BITS-1]};
    r     = l;
    if (trial >= {1'b0, d}) begin
      trial  = trial - {1'b0, d};
      r.bits = {l.bits[QUO_BITS-2:0], 1'b1};
    end else begin
      r.bits = {l.bits[QUO_BITS-2:0], 1'b0};
    end
    r.rem = trial[COORD_W-1:0];
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      stg_next[k] = (k == 0) ? in_word : stg[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < DIV_STEP; j++) begin
        stg_next[k].lx = div_step(stg_next[k].lx, stg_next[k].den);
        stg_next[k].ly = div_step(stg_next[k].ly, stg_next[k].den);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_word  = stg[DIV_STAGES-1];

endmodule

// ----- src/cpp_output.sv -----
// Screen placement, saturation, bounds test and output skid buffer.
module cpp_output
  import cpp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      tail_valid,
  input  div_word_t tail_word,
  output logic      en,
  input  logic      out_ready,
  output logic      out_valid,
  output coord_t    screen_x,
  output coord_t    screen_y,
  output logic      in_front,
  output logic      on_screen
);

  localparam int MARGIN_X = SCREEN_WIDTH / 4;
  localparam int MARGIN_Y = SCREEN_HEIGHT / 4;
  localparam int ONE      = 1 << FRAC_BITS;
  localparam logic signed [35:0] CENTER_X = 36'((SCREEN_WIDTH / 2) * ONE);
  localparam logic signed [35:0] CENTER_Y = 36'((SCREEN_HEIGHT / 2) * ONE);
  localparam coord_t X_LO  = 32'(-MARGIN_X * ONE);
  localparam coord_t X_HI  = 32'((SCREEN_WIDTH + MARGIN_X) * ONE);
  localparam coord_t Y_LO  = 32'(-MARGIN_Y * ONE);
  localparam coord_t Y_HI  = 32'((SCREEN_HEIGHT + MARGIN_Y) * ONE);
  localparam coord_t OFF_X = 32'((-MARGIN_X - 1) * ONE);
  localparam coord_t OFF_Y = 32'((-MARGIN_Y - 1) * ONE);

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    logic   front;
    logic   on;
  } res_t;

  logic signed [35:0] qx, qy;
  coord_t             sx, sy;
  res_t               res, out_res, skid_res;
  logic               skid_valid;

  // an overflowed quotient saturates either way
  assign qx = tail_word.lx.ovf ? 36'sd8589934592 : $signed({3'b000, tail_word.lx.bits});
  assign qy = tail_word.ly.ovf ? 36'sd8589934592 : $signed({3'b000, tail_word.ly.bits});
  assign sx = sat32(64'(CENTER_X + (tail_word.lx.pos ? qx : -qx)));
  assign sy = sat32(64'(CENTER_Y + (tail_word.ly.pos ? -qy : qy)));

  always_comb begin
    res.front = tail_word.front;
    if (tail_word.front) begin
      res.sx = sx;
      res.sy = sy;
      res.on = (sx >= X_LO) && (sx <= X_HI) && (sy >= Y_LO) && (sy <= Y_HI);
    end else begin
      res.sx = OFF_X;
      res.sy = OFF_Y;
      res.on = 1'b0;
    end
  end

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (tail_valid) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end else begin
        out_valid <= 1'b1;
        out_res   <= res;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign screen_x  = out_res.sx;
  assign screen_y  = out_res.sy;
  assign in_front  = out_res.front;
  assign on_screen = out_res.on;

endmodule

// ----- src/camera_perspective_projector_top.sv -----
// Camera perspective projector top level: config registers and pipeline.
//
//   port group   dir  handshake              words
//   vertex       in   in_valid / in_ready    vertex_x, vertex_y, vertex_z
//   screen       out  out_valid / out_ready  screen_x, screen_y, in_front, on_screen
//   config       in   cfg_write              cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; stages: difference, two rotations
// of two stages, two projection stages, 11 divider stages, output register.
// The divider, three quotient bits per stage, sets the depth.
// Reset clears all valid bits and loads the register defaults.
// A stalled output fills a one-word skid buffer; the pipeline then holds.
module camera_perspective_projector_top
  import cpp_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  coord_t               vertex_x,
  input  coord_t               vertex_y,
  input  coord_t               vertex_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output coord_t               screen_x,
  output coord_t               screen_y,
  output logic                 in_front,
  output logic                 on_screen,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  coord_t                   camera_x, camera_y, camera_z;
  logic signed [TRIG_W-1:0] yaw_cosine, yaw_sine, pitch_cosine, pitch_sine;
  logic [FOCAL_W-1:0]       focal_scale;

  logic      en;
  logic      d_valid;
  coord_t    dx, dy, dz;
  logic      yaw_valid, pitch_valid, proj_valid, tail_valid;
  coord_t    x1, z1, dy_c, y2, z2, x1_c;
  div_word_t proj_word, tail_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x     <= '0;
      camera_y     <= '0;
      camera_z     <= '0;
      yaw_cosine   <= RESET_COSINE;
      yaw_sine     <= '0;
      pitch_cosine <= RESET_COSINE;
      pitch_sine   <= '0;
      focal_scale  <= RESET_FOCAL;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CAMERA_X:     camera_x     <= cfg_data;
        REG_CAMERA_Y:     camera_y     <= cfg_data;
        REG_CAMERA_Z:     camera_z     <= cfg_data;
        REG_YAW_COSINE:   yaw_cosine   <= cfg_data[TRIG_W-1:0];
        REG_YAW_SINE:     yaw_sine     <= cfg_data[TRIG_W-1:0];
        REG_PITCH_COSINE: pitch_cosine <= cfg_data[TRIG_W-1:0];
        REG_PITCH_SINE:   pitch_sine   <= cfg_data[TRIG_W-1:0];
        REG_FOCAL_SCALE:  focal_scale  <= cfg_data[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= in_valid;
    end
    if (en) begin
      dx <= sat32(64'(vertex_x) - 64'(camera_x));
      dy <= sat32(64'(vertex_y) - 64'(camera_y));
      dz <= sat32(64'(vertex_z) - 64'(camera_z));
    end
  end

  cpp_rotate u_yaw (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .a         (dx),
    .b         (dz),
    .cosv      (yaw_cosine),
    .sinv      (yaw_sine),
    .carry_in  (dy),
    .out_valid (yaw_valid),
    .p         (x1),
    .q         (z1),
    .carry_out (dy_c)
  );

  cpp_rotate u_pitch (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (yaw_valid),
    .a         (dy_c),
    .b         (z1),
    .cosv      (pitch_cosine),
    .sinv      (pitch_sine),
    .carry_in  (x1),
    .out_valid (pitch_valid),
    .p         (y2),
    .q         (z2),
    .carry_out (x1_c)
  );

  cpp_project u_project (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pitch_valid),
    .x1        (x1_c),
    .y2        (y2),
    .z2        (z2),
    .focal     (focal_scale),
    .out_valid (proj_valid),
    .out_word  (proj_word)
  );

  cpp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (proj_valid),
    .in_word   (proj_word),
    .out_valid (tail_valid),
    .out_word  (tail_word)
  );

  cpp_output #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_output (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (tail_valid),
    .tail_word  (tail_word),
    .en         (en),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .in_front   (in_front),
    .on_screen  (on_screen)
  );

endmodule
